// ----- rtl/assert_macros.svh -----
// assertion helpers, sampled on clk with rst_n low as the disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/swr_pkg.sv -----
`default_nettype none

package swr_pkg;

  // default sizes
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int LEN_W      = 7;
  localparam int COUNT_W    = 7;
  localparam int Q_W        = 23;
  localparam int FRAC_W     = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN     = 2'd0,
    CFG_RANK_METHOD    = 2'd1,
    CFG_PERCENT_ENABLE = 2'd2,
    CFG_PERCENT_MODE   = 2'd3
  } cfg_idx_t;

  // tie rule
  typedef enum logic [1:0] {
    RANK_AVERAGE = 2'd0,
    RANK_MIN     = 2'd1,
    RANK_MAX     = 2'd2,
    RANK_FIRST   = 2'd3
  } rank_method_t;

  // percentile scaling
  typedef enum logic {
    PCT_OVER_COUNT = 1'b0,
    PCT_CLOSED     = 1'b1
  } scale_mode_t;

endpackage

`default_nettype wire

// ----- rtl/sliding_window_rank.sv -----
// Rank of the newest sample among the last window_len samples, missing samples never counted
// as lower or equal. Samples sit in a row of MAX_WINDOW cells that shifts by one place per
// accepted item; every cell compares its entry with the new sample and the partial counts
// ripple down the row one cell per cycle, after which the item passes through the sum and
// scale steps. With the percentile on, an item whose rank is divided then goes through a
// bit-serial divider. One item is in work at a time; a finished result waits in the output
// register while the next item is taken in. A missing sample or a window still filling
// gives rank_valid low and rank_q16 zero. Configuration is written through the cfg_ port,
// which is always ready; the window length is taken when an item is accepted, while rank
// method and percentile settings are read as the item in work reaches them.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_rank #(
  parameter int MAX_WINDOW  = swr_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swr_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [swr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swr_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample items
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [SAMPLE_BITS-1:0]         in_sample,
  input  wire logic                           in_sample_missing,
  // result items
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_rank_valid,
  output logic      [swr_pkg::Q_W-1:0]        out_rank_q16,
  output logic      [swr_pkg::COUNT_W-1:0]    out_count_below,
  output logic      [swr_pkg::COUNT_W-1:0]    out_count_not_above,
  output logic      [swr_pkg::COUNT_W-1:0]    out_missing_in_window
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int RANK_W = CNT_W + 17;

  localparam logic [RANK_W-1:0] Q16_ONE  = RANK_W'(1) << swr_pkg::FRAC_W;
  localparam logic [RANK_W-1:0] Q16_HALF = RANK_W'(1) << (swr_pkg::FRAC_W - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_COUNT = 6'b000010,
    ST_SUM   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // configuration registers
  logic [swr_pkg::LEN_W-1:0] window_len_r;
  swr_pkg::rank_method_t     rank_method_r;
  logic                      percent_enable_r;
  swr_pkg::scale_mode_t      percent_mode_r;

  // item context
  logic [CNT_W-1:0]       fill_count_r;
  logic [CNT_W-1:0]       fill_nxt;
  logic [CNT_W-1:0]       wl;
  logic [CNT_W-1:0]       n_nxt;
  logic [CNT_W-1:0]       n_r;
  logic [CNT_W-1:0]       wl_r;
  logic                   valid_r;
  logic [SAMPLE_BITS-1:0] new_key;
  logic [SAMPLE_BITS-1:0] q_key_r;
  logic                   q_miss_r;
  logic [IDX_W-1:0]       step_r;

  // counting results
  logic [CNT_W-1:0]  below_r;
  logic [CNT_W-1:0]  not_above_r;
  logic [CNT_W-1:0]  missing_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RANK_W-1:0] rank_nxt;
  logic [RANK_W-1:0] rank_r;
  logic [RANK_W-1:0] res_r;

  // divider hookup
  logic              div_start;
  logic [RANK_W-1:0] div_dvd;
  logic [CNT_W-1:0]  div_dvs;
  logic              div_done;
  logic [RANK_W-1:0] div_quo;

  // output register
  logic                        out_valid_r;
  logic                        out_rank_valid_r;
  logic [swr_pkg::Q_W-1:0]     out_rank_q16_r;
  logic [swr_pkg::COUNT_W-1:0] out_below_r;
  logic [swr_pkg::COUNT_W-1:0] out_not_above_r;
  logic [swr_pkg::COUNT_W-1:0] out_missing_r;
  logic                        out_load;

  logic in_acc;

  // cell row wiring
  logic [SAMPLE_BITS-1:0] key_w       [0:MAX_WINDOW];
  logic                   miss_w      [0:MAX_WINDOW];
  logic [CNT_W-1:0]       below_w     [0:MAX_WINDOW];
  logic [CNT_W-1:0]       not_above_w [0:MAX_WINDOW];
  logic [CNT_W-1:0]       missing_w   [0:MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  in_win;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r     <= swr_pkg::LEN_RESET;
      rank_method_r    <= swr_pkg::RANK_AVERAGE;
      percent_enable_r <= 1'b0;
      percent_mode_r   <= swr_pkg::PCT_OVER_COUNT;
    end else if (cfg_valid) begin
      unique case (swr_pkg::cfg_idx_t'(cfg_index))
        swr_pkg::CFG_WINDOW_LEN:     window_len_r <= cfg_data;
        swr_pkg::CFG_RANK_METHOD:    rank_method_r <= swr_pkg::rank_method_t'(cfg_data[1:0]);
        swr_pkg::CFG_PERCENT_ENABLE: percent_enable_r <= cfg_data[0];
        swr_pkg::CFG_PERCENT_MODE:   percent_mode_r <= swr_pkg::scale_mode_t'(cfg_data[0]);
      endcase
    end
  end

  // effective window length: zero acts as one, clipped to the row length
  always_comb begin
    if (window_len_r == '0) begin
      wl = CNT_W'(1);
    end else if (32'(window_len_r) > MAX_WINDOW) begin
      wl = CNT_W'(MAX_WINDOW);
    end else begin
      wl = CNT_W'(window_len_r);
    end
  end

  // fill level after this item and span to count
  assign fill_nxt = (32'(fill_count_r) < MAX_WINDOW) ? fill_count_r + CNT_W'(1) : fill_count_r;
  assign n_nxt    = (fill_nxt < wl) ? fill_nxt : wl;

  // sign bit flipped so unsigned compare gives signed order
  assign new_key = {~in_sample[SAMPLE_BITS-1], in_sample[SAMPLE_BITS-2:0]};

  assign key_w[0]       = new_key;
  assign miss_w[0]      = in_sample_missing;
  assign below_w[0]     = '0;
  assign not_above_w[0] = '0;
  assign missing_w[0]   = '0;

  // row of cells, newest entry in cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    assign in_win[i] = CNT_W'(i) < n_r;

    swr_cell #(
      .KEY_W (SAMPLE_BITS),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk           (clk),
      .shift         (in_acc),
      .key_in        (key_w[i]),
      .miss_in       (miss_w[i]),
      .key_out       (key_w[i+1]),
      .miss_out      (miss_w[i+1]),
      .q_key         (q_key_r),
      .q_miss        (q_miss_r),
      .en            (in_win[i]),
      .below_in      (below_w[i]),
      .not_above_in  (not_above_w[i]),
      .missing_in    (missing_w[i]),
      .below_out     (below_w[i+1]),
      .not_above_out (not_above_w[i+1]),
      .missing_out   (missing_w[i+1])
    );
  end

  // rank from the finished counts
  always_comb begin
    unique case (rank_method_r)
      swr_pkg::RANK_AVERAGE:
        rank_nxt = (RANK_W'(below_w[MAX_WINDOW]) + RANK_W'(not_above_w[MAX_WINDOW])
                    + RANK_W'(1)) << (swr_pkg::FRAC_W - 1);
      swr_pkg::RANK_MIN:
        rank_nxt = (RANK_W'(below_w[MAX_WINDOW]) + RANK_W'(1)) << swr_pkg::FRAC_W;
      swr_pkg::RANK_MAX, swr_pkg::RANK_FIRST:
        rank_nxt = RANK_W'(not_above_w[MAX_WINDOW]) << swr_pkg::FRAC_W;
    endcase
  end

  // percentile division request
  always_comb begin
    div_start = 1'b0;
    div_dvd   = rank_r;
    div_dvs   = cnt_r;
    if (state_r == ST_SCALE && valid_r && percent_enable_r) begin
      if (percent_mode_r == swr_pkg::PCT_OVER_COUNT) begin
        div_start = 1'b1;
      end else if (cnt_r != CNT_W'(1)) begin
        div_start = 1'b1;
        div_dvd   = rank_r - Q16_ONE;
        div_dvs   = cnt_r - CNT_W'(1);
      end
    end
  end

  swr_div #(
    .DVD_W (RANK_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_COUNT;
      ST_COUNT: if (step_r == '0) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = div_start ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        fill_count_r <= fill_nxt;
      end
    end
  end

  // item context and counting phase
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_key_r  <= new_key;
      q_miss_r <= in_sample_missing;
      n_r      <= n_nxt;
      wl_r     <= wl;
      valid_r  <= (fill_nxt >= wl) && !in_sample_missing;
      step_r   <= IDX_W'(MAX_WINDOW - 1);
    end else if (state_r == ST_COUNT) begin
      step_r <= step_r - IDX_W'(1);
    end
  end

  // gather counts, then scale
  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      below_r     <= below_w[MAX_WINDOW];
      not_above_r <= not_above_w[MAX_WINDOW];
      missing_r   <= missing_w[MAX_WINDOW];
      cnt_r       <= wl_r - missing_w[MAX_WINDOW];
      rank_r      <= valid_r ? rank_nxt : '0;
    end
    if (state_r == ST_SCALE && !div_start) begin
      if (valid_r && percent_enable_r) begin
        res_r <= Q16_HALF;
      end else begin
        res_r <= rank_r;
      end
    end else if (state_r == ST_DIV && div_done) begin
      res_r <= div_quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rank_valid_r <= valid_r;
      out_rank_q16_r   <= swr_pkg::Q_W'(res_r);
      out_below_r      <= swr_pkg::COUNT_W'(below_r);
      out_not_above_r  <= swr_pkg::COUNT_W'(not_above_r);
      out_missing_r    <= swr_pkg::COUNT_W'(missing_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_rank_valid        = out_rank_valid_r;
  assign out_rank_q16          = out_rank_q16_r;
  assign out_count_below       = out_below_r;
  assign out_count_not_above   = out_not_above_r;
  assign out_missing_in_window = out_missing_r;

  // checks
  `SWR_ASSERT_NEXT(a_accept_starts_count, in_acc, state_r == ST_COUNT, "item did not start counting")
  `SWR_ASSERT_NOW(a_fill_bounded, 1'b1, 32'(fill_count_r) <= MAX_WINDOW, "fill count overran")
  `SWR_ASSERT_NOW(a_div_done_in_div, div_done, state_r == ST_DIV, "divider finished out of turn")
  `SWR_ASSERT_NOW(a_span_within_fill, state_r == ST_COUNT, n_r <= fill_count_r, "span past fill")

endmodule

`default_nettype wire

// ----- rtl/swr_cell.sv -----
`default_nettype none

module swr_cell #(
  parameter int KEY_W = swr_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic [KEY_W-1:0] key_in,
  input  wire logic             miss_in,
  output logic      [KEY_W-1:0] key_out,
  output logic                  miss_out,
  input  wire logic [KEY_W-1:0] q_key,
  input  wire logic             q_miss,
  input  wire logic             en,
  input  wire logic [CNT_W-1:0] below_in,
  input  wire logic [CNT_W-1:0] not_above_in,
  input  wire logic [CNT_W-1:0] missing_in,
  output logic      [CNT_W-1:0] below_out,
  output logic      [CNT_W-1:0] not_above_out,
  output logic      [CNT_W-1:0] missing_out
);

  logic [KEY_W-1:0] key_r;
  logic             miss_r;
  logic [CNT_W-1:0] below_r;
  logic [CNT_W-1:0] not_above_r;
  logic [CNT_W-1:0] missing_r;
  logic             is_lt;
  logic             is_le;
  logic             is_miss;

  // stored entry moves one place along the row per item
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r  <= key_in;
      miss_r <= miss_in;
    end
  end

  // local compare against the query
  assign is_miss = en && miss_r;
  assign is_lt   = en && !miss_r && !q_miss && (key_r < q_key);
  assign is_le   = en && !miss_r && !q_miss && (key_r <= q_key);

  // partial counts ripple one cell per cycle
  always_ff @(posedge clk) begin
    below_r     <= below_in + CNT_W'(is_lt);
    not_above_r <= not_above_in + CNT_W'(is_le);
    missing_r   <= missing_in + CNT_W'(is_miss);
  end

  assign key_out       = key_r;
  assign miss_out      = miss_r;
  assign below_out     = below_r;
  assign not_above_out = not_above_r;
  assign missing_out   = missing_r;

endmodule

`default_nettype wire

// ----- rtl/swr_div.sv -----
`default_nettype none

module swr_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVS_W:0]    rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_diff;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign rem_sh   = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign fits     = rem_sh >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_W'(DVD_W);
    end else if (busy_r) begin
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_diff : rem_sh;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire
